[rtl/core/segint_pkg.sv]
// Package for the segment intersection classifier.
// Holds widths, result and mode codes, and the divider step function.
// No dependencies.
`default_nettype none

package segint_pkg;

  // Input coordinate and output fixed-point sizes.
  localparam int CoordBits = 16;
  localparam int FracBits  = 8;
  localparam int OutBits   = 24;

  // Derived widths: differences, products, sums, divider operands.
  localparam int DiffW = CoordBits + 1;
  localparam int ProdW = 2 * DiffW;
  localparam int SumW  = ProdW + 1;
  localparam int BndW  = SumW + 3;
  localparam int NumW  = 2 * CoordBits + 2;
  localparam int QuoW  = CoordBits + FracBits + 1;
  localparam int DivW  = NumW + QuoW;
  localparam int PosW  = ((CoordBits + FracBits + 2) > OutBits ?
                          (CoordBits + FracBits + 2) : OutBits) + 1;

  // Result classes.
  typedef enum logic [1:0] {
    KIND_EMPTY   = 2'd0,
    KIND_APART   = 2'd1,
    KIND_POINT   = 2'd2,
    KIND_OVERLAP = 2'd3
  } kind_t;

  // Second object kinds.
  localparam logic [1:0] MODE_SEG  = 2'd0;
  localparam logic [1:0] MODE_RAY  = 2'd1;
  localparam logic [1:0] MODE_LINE = 2'd2;
  localparam logic [1:0] MODE_ALT  = 2'd3;

  // One restoring division step on {remainder, dividend-low/quotient}.
  function automatic logic [DivW-1:0] div_step(input logic [DivW-1:0] word,
                                                input logic [NumW-1:0] den);
    logic [NumW:0]   t;
    logic [NumW-1:0] r;
    logic [QuoW-1:0] low;
    t   = {word[DivW-1:QuoW], word[QuoW-1]};
    low = {word[QuoW-2:0], 1'b0};
    r   = t[NumW-1:0];
    if (t >= {1'b0, den}) begin
      r      = NumW'(t - {1'b0, den});
      low[0] = 1'b1;
    end
    return {r, low};
  endfunction

endpackage

`default_nettype wire

[rtl/core/segment_intersection_classifier.sv]
// Top level of the segment intersection classifier.
// Depends on segint_pkg and segint_div.
//
// Usage: a request on the input channel (in_valid/in_ready) carries one
// first segment, one second object and its mode. Each request yields
// exactly one result on the output channel (out_valid/out_ready): a class
// and two fixed-point points, zero when there is no intersection.
// A request passes the difference, product, sum, normalization, class and
// scaling stages, the quotient dividers (one bit per stage) and the output register.
// Throughput is one request per cycle while the receiver takes results.
// Reset clears all stage valid bits; the pipeline then holds no request.
// When the receiver stalls, the whole pipeline holds its contents and
// in_ready drops in the same cycle, so nothing is lost or repeated.
`default_nettype none

module segment_intersection_classifier
  import segint_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  mode,
  input  wire logic signed [CoordBits-1:0] first_start_x,
  input  wire logic signed [CoordBits-1:0] first_start_y,
  input  wire logic signed [CoordBits-1:0] first_end_x,
  input  wire logic signed [CoordBits-1:0] first_end_y,
  input  wire logic signed [CoordBits-1:0] other_origin_x,
  input  wire logic signed [CoordBits-1:0] other_origin_y,
  input  wire logic signed [CoordBits-1:0] other_point_x,
  input  wire logic signed [CoordBits-1:0] other_point_y,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       kind,
  output logic signed [OutBits-1:0]        hit_x,
  output logic signed [OutBits-1:0]        hit_y,
  output logic signed [OutBits-1:0]        end_x,
  output logic signed [OutBits-1:0]        end_y
);

  typedef struct packed {
    kind_t                       kind;
    logic                        negx;
    logic                        negy;
    logic signed [CoordBits-1:0] px;
    logic signed [CoordBits-1:0] py;
  } meta_t;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: differences.
  logic                        s1_v;
  logic [1:0]                  s1_mode;
  logic signed [CoordBits-1:0] s1_px, s1_py;
  logic signed [DiffW-1:0]     s1_d0x, s1_d0y, s1_d1x, s1_d1y, s1_ex, s1_ey;

  // Stage 2: products.
  logic                        s2_v;
  logic [1:0]                  s2_mode;
  logic signed [CoordBits-1:0] s2_px, s2_py;
  logic signed [DiffW-1:0]     s2_d0x, s2_d0y;
  logic signed [ProdW-1:0]     s2_k1, s2_k2, s2_s1, s2_s2, s2_t1, s2_t2;
  logic signed [ProdW-1:0]     s2_l1, s2_l2, s2_a1, s2_a2, s2_g1, s2_g2;

  // Stage 3: cross and dot sums.
  logic                        s3_v;
  logic [1:0]                  s3_mode;
  logic signed [CoordBits-1:0] s3_px, s3_py;
  logic signed [DiffW-1:0]     s3_d0x, s3_d0y;
  logic signed [SumW-1:0]      s3_k, s3_sn, s3_tn, s3_len, s3_a, s3_g;

  // Stage 4: sign normalization and parameter interval.
  logic                        s4_v;
  logic [1:0]                  s4_mode;
  logic signed [CoordBits-1:0] s4_px, s4_py;
  logic signed [DiffW-1:0]     s4_d0x, s4_d0y;
  logic                        s4_lenz, s4_kz, s4_tz, s4_ok;
  logic [NumW-1:0]             s4_kmag, s4_snn;
  logic signed [SumW-1:0]      s4_len;
  logic signed [BndW-1:0]      s4_lo, s4_hi;

  // Stage 5: class and division operands.
  logic                        s5_v;
  kind_t                       s5_kind;
  logic signed [CoordBits-1:0] s5_px, s5_py;
  logic signed [DiffW-1:0]     s5_d0x, s5_d0y;
  logic [NumW-1:0]             s5_num0, s5_num1, s5_den;

  // Stage 6: scaled numerators.
  logic                        s6_v;
  meta_t                       s6_meta;
  logic [DivW-1:0]             s6_n0x, s6_n0y, s6_n1x, s6_n1y;
  logic [NumW-1:0]             s6_den;

  // Stage 1 logic.
  logic [1:0] mode_n;
  always_comb begin
    mode_n = (mode == MODE_ALT) ? MODE_LINE : mode;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode <= mode_n;
      s1_px   <= first_start_x;
      s1_py   <= first_start_y;
      s1_d0x  <= DiffW'(first_end_x) - DiffW'(first_start_x);
      s1_d0y  <= DiffW'(first_end_y) - DiffW'(first_start_y);
      s1_d1x  <= DiffW'(other_point_x) - DiffW'(other_origin_x);
      s1_d1y  <= DiffW'(other_point_y) - DiffW'(other_origin_y);
      s1_ex   <= DiffW'(other_origin_x) - DiffW'(first_start_x);
      s1_ey   <= DiffW'(other_origin_y) - DiffW'(first_start_y);
    end
  end

  // Stage 2 logic: the products for the cross and dot sums.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mode <= s1_mode;
      s2_px   <= s1_px;
      s2_py   <= s1_py;
      s2_d0x  <= s1_d0x;
      s2_d0y  <= s1_d0y;
      s2_k1   <= ProdW'(s1_d0x) * ProdW'(s1_d1y);
      s2_k2   <= ProdW'(s1_d0y) * ProdW'(s1_d1x);
      s2_s1   <= ProdW'(s1_ex) * ProdW'(s1_d1y);
      s2_s2   <= ProdW'(s1_ey) * ProdW'(s1_d1x);
      s2_t1   <= ProdW'(s1_ex) * ProdW'(s1_d0y);
      s2_t2   <= ProdW'(s1_ey) * ProdW'(s1_d0x);
      s2_l1   <= ProdW'(s1_d0x) * ProdW'(s1_d0x);
      s2_l2   <= ProdW'(s1_d0y) * ProdW'(s1_d0y);
      s2_a1   <= ProdW'(s1_d0x) * ProdW'(s1_ex);
      s2_a2   <= ProdW'(s1_d0y) * ProdW'(s1_ey);
      s2_g1   <= ProdW'(s1_d0x) * ProdW'(s1_d1x);
      s2_g2   <= ProdW'(s1_d0y) * ProdW'(s1_d1y);
    end
  end

  // Stage 3 logic: cross products and dot products.
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_mode <= s2_mode;
      s3_px   <= s2_px;
      s3_py   <= s2_py;
      s3_d0x  <= s2_d0x;
      s3_d0y  <= s2_d0y;
      s3_k    <= SumW'(s2_k1) - SumW'(s2_k2);
      s3_sn   <= SumW'(s2_s1) - SumW'(s2_s2);
      s3_tn   <= SumW'(s2_t1) - SumW'(s2_t2);
      s3_len  <= SumW'(s2_l1) + SumW'(s2_l2);
      s3_a    <= SumW'(s2_a1) + SumW'(s2_a2);
      s3_g    <= SumW'(s2_g1) + SumW'(s2_g2);
    end
  end

  // Stage 4 logic: normalize the cross sign, build the overlap interval.
  logic signed [SumW-1:0] kabs, snn, tnn;
  logic signed [BndW-1:0] av, bv, lenv, seg_lo, seg_hi, ray_lo, ray_hi;
  logic                   okv;
  always_comb begin
    kabs = s3_k[SumW-1] ? -s3_k : s3_k;
    snn  = s3_k[SumW-1] ? -s3_sn : s3_sn;
    tnn  = s3_k[SumW-1] ? -s3_tn : s3_tn;
    okv  = (snn >= 0) && (snn <= kabs);
    if (s3_mode == MODE_SEG) begin
      okv = okv && (tnn >= 0) && (tnn <= kabs);
    end else if (s3_mode == MODE_RAY) begin
      okv = okv && (tnn >= 0);
    end
    av     = BndW'(s3_a);
    bv     = av + BndW'(s3_g);
    lenv   = BndW'(s3_len);
    seg_lo = (av < bv) ? av : bv;
    seg_hi = (av < bv) ? bv : av;
    ray_lo = av;
    ray_hi = av;
    if (s3_g > 0) begin
      ray_hi = ((av > lenv) ? av : lenv) + BndW'(1);
    end else if (s3_g < 0) begin
      ray_lo = ((av < 0) ? av : BndW'(0)) - BndW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_mode <= s3_mode;
      s4_px   <= s3_px;
      s4_py   <= s3_py;
      s4_d0x  <= s3_d0x;
      s4_d0y  <= s3_d0y;
      s4_lenz <= (s3_len == 0);
      s4_kz   <= (s3_k == 0);
      s4_tz   <= (s3_tn == 0);
      s4_ok   <= okv;
      s4_kmag <= NumW'(kabs);
      s4_snn  <= NumW'(snn);
      s4_len  <= s3_len;
      s4_lo   <= (s3_mode == MODE_RAY) ? ray_lo : seg_lo;
      s4_hi   <= (s3_mode == MODE_RAY) ? ray_hi : seg_hi;
    end
  end

  // Stage 5 logic: pick the class and the fractions to place.
  kind_t                  kind5;
  logic [NumW-1:0]        num0, num1, den5;
  logic signed [BndW-1:0] len5, u0, u1;
  always_comb begin
    kind5 = KIND_EMPTY;
    num0  = '0;
    num1  = '0;
    den5  = NumW'(1);
    len5  = BndW'(s4_len);
    u0    = '0;
    u1    = '0;
    if (s4_lenz) begin
      kind5 = KIND_EMPTY;
    end else if (!s4_kz) begin
      if (s4_ok) begin
        kind5 = KIND_POINT;
        num0  = s4_snn;
        num1  = s4_snn;
        den5  = s4_kmag;
      end
    end else if (!s4_tz) begin
      kind5 = KIND_APART;
    end else if (s4_mode == MODE_LINE) begin
      kind5 = KIND_OVERLAP;
      num1  = NumW'(s4_len);
      den5  = NumW'(s4_len);
    end else if ((len5 < s4_lo) || (s4_hi < 0)) begin
      kind5 = KIND_APART;
    end else begin
      kind5 = KIND_OVERLAP;
      den5  = NumW'(s4_len);
      if (len5 > s4_lo) begin
        if (s4_hi > 0) begin
          u0 = (s4_lo > 0) ? s4_lo : BndW'(0);
          u1 = (s4_hi < len5) ? s4_hi : len5;
        end
      end else begin
        u0 = len5;
        u1 = len5;
      end
      num0 = NumW'(u0);
      num1 = NumW'(u1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_kind <= kind5;
      s5_px   <= s4_px;
      s5_py   <= s4_py;
      s5_d0x  <= s4_d0x;
      s5_d0y  <= s4_d0y;
      s5_num0 <= num0;
      s5_num1 <= num1;
      s5_den  <= den5;
    end
  end

  // Stage 6 logic: scale the fractions by the fixed-point direction.
  logic signed [DiffW-1:0] absx, absy;
  logic [QuoW-1:0]         magx, magy;
  always_comb begin
    absx = s5_d0x[DiffW-1] ? -s5_d0x : s5_d0x;
    absy = s5_d0y[DiffW-1] ? -s5_d0y : s5_d0y;
    magx = QuoW'(absx[CoordBits-1:0]) << FracBits;
    magy = QuoW'(absy[CoordBits-1:0]) << FracBits;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_meta.kind <= s5_kind;
      s6_meta.negx <= s5_d0x[DiffW-1];
      s6_meta.negy <= s5_d0y[DiffW-1];
      s6_meta.px   <= s5_px;
      s6_meta.py   <= s5_py;
      s6_n0x       <= DivW'(s5_num0) * DivW'(magx);
      s6_n0y       <= DivW'(s5_num0) * DivW'(magy);
      s6_n1x       <= DivW'(s5_num1) * DivW'(magx);
      s6_n1y       <= DivW'(s5_num1) * DivW'(magy);
      s6_den       <= s5_den;
    end
  end

  // Dividers, one per output coordinate.
  logic [QuoW-1:0] q_hx, q_hy, q_nx, q_ny;
  logic            r_hx, r_hy, r_nx, r_ny;

  segint_div u_div_hx (.clk(clk), .en(adv), .num_in(s6_n0x), .den_in(s6_den),
                       .quo(q_hx), .rem_nz(r_hx));
  segint_div u_div_hy (.clk(clk), .en(adv), .num_in(s6_n0y), .den_in(s6_den),
                       .quo(q_hy), .rem_nz(r_hy));
  segint_div u_div_nx (.clk(clk), .en(adv), .num_in(s6_n1x), .den_in(s6_den),
                       .quo(q_nx), .rem_nz(r_nx));
  segint_div u_div_ny (.clk(clk), .en(adv), .num_in(s6_n1y), .den_in(s6_den),
                       .quo(q_ny), .rem_nz(r_ny));

  // Side data that travels with the dividers.
  meta_t meta [QuoW];
  always_ff @(posedge clk) begin
    if (adv) begin
      meta[0] <= s6_meta;
      for (int s = 1; s < QuoW; s++) begin
        meta[s] <= meta[s-1];
      end
    end
  end

  // Valid bits for every stage.
  logic [QuoW-1:0] dv;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      s5_v      <= 1'b0;
      s6_v      <= 1'b0;
      dv        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= in_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v;
      s5_v      <= s4_v;
      s6_v      <= s5_v;
      dv        <= {dv[QuoW-2:0], s6_v};
      out_valid <= dv[QuoW-1];
    end
  end

  // Final placement: floor the offset, add the start point, saturate.
  function automatic logic signed [OutBits-1:0] place(
      input logic signed [CoordBits-1:0] p, input logic neg,
      input logic [QuoW-1:0] q, input logic rnz);
    logic signed [PosW-1:0] off;
    logic signed [PosW-1:0] pos;
    logic signed [OutBits-1:0] res;
    off = PosW'(q);
    if (neg) begin
      off = -(off + PosW'(rnz));
    end
    pos = (PosW'(p) <<< FracBits) + off;
    res = pos[OutBits-1:0];
    if (pos[PosW-1:OutBits-1] != {(PosW-OutBits+1){pos[PosW-1]}}) begin
      res = pos[PosW-1] ? {1'b1, {(OutBits-1){1'b0}}} : {1'b0, {(OutBits-1){1'b1}}};
    end
    return res;
  endfunction

  meta_t mo;
  logic  has_pt;
  assign mo     = meta[QuoW-1];
  assign has_pt = (mo.kind == KIND_POINT) || (mo.kind == KIND_OVERLAP);

  always_ff @(posedge clk) begin
    if (adv) begin
      kind  <= mo.kind;
      hit_x <= has_pt ? place(mo.px, mo.negx, q_hx, r_hx) : '0;
      hit_y <= has_pt ? place(mo.py, mo.negy, q_hy, r_hy) : '0;
      end_x <= has_pt ? place(mo.px, mo.negx, q_nx, r_nx) : '0;
      end_y <= has_pt ? place(mo.py, mo.negy, q_ny, r_ny) : '0;
    end
  end

endmodule

`default_nettype wire

[rtl/core/segint_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on segint_pkg for widths and the step function.
`default_nettype none

module segint_div
  import segint_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DivW-1:0]  num_in,
  input  wire logic [NumW-1:0]  den_in,
  output logic      [QuoW-1:0]  quo,
  output logic                  rem_nz
);

  logic [DivW-1:0] word [QuoW];
  logic [NumW-1:0] den  [QuoW];

  // Each stage retires one quotient bit; the divisor travels alongside.
  always_ff @(posedge clk) begin
    if (en) begin
      word[0] <= div_step(num_in, den_in);
      den[0]  <= den_in;
      for (int s = 1; s < QuoW; s++) begin
        word[s] <= div_step(word[s-1], den[s-1]);
        den[s]  <= den[s-1];
      end
    end
  end

  assign quo    = word[QuoW-1][QuoW-1:0];
  assign rem_nz = |word[QuoW-1][DivW-1:QuoW];

endmodule

`default_nettype wire

[rtl/core/segint_check.sv]
// Port-level checks for the segment intersection classifier.
// Depends on segint_pkg; bound to segment_intersection_classifier.
`default_nettype none

module segint_check
  import segint_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [1:0]               kind,
  input wire logic signed [OutBits-1:0] hit_x,
  input wire logic signed [OutBits-1:0] hit_y,
  input wire logic signed [OutBits-1:0] end_x,
  input wire logic signed [OutBits-1:0] end_y
);

  // A stalled result holds its class and hit_x.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(hit_x))
    else $error("stalled result changed");

  // No point is reported without an intersection.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_EMPTY || kind == KIND_APART) |->
    hit_x == 0 && hit_y == 0 && end_x == 0 && end_y == 0)
    else $error("nonzero point for empty or parallel class");

  // A unique point reports the same start and end.
  a_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_POINT |-> end_x == hit_x && end_y == hit_y)
    else $error("unique point with differing end");

  // Input is refused while the receiver stalls a result.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");

endmodule

bind segment_intersection_classifier segint_check u_segint_check (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .kind(kind), .hit_x(hit_x), .hit_y(hit_y),
  .end_x(end_x), .end_y(end_y)
);

`default_nettype wire
